// ===== hw/rtl/ladlp_pkg.sv =====
package ladlp_pkg;

	localparam int STAGE_COUNT = 4;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam int DATA_W = 32;
	localparam int PROD_W = 65;
	localparam int ACC_W = 34;
	localparam int PC_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF = 3'd5;

	localparam logic [15:0] DRIVE_RST = 16'd4096;
	localparam logic [19:0] C1_RST = 20'd65536;
	localparam logic [19:0] C3_RST = 20'd21845;
	localparam logic [19:0] C5_RST = 20'd13107;
	localparam logic [15:0] RES_RST = 16'd8192;
	localparam logic [15:0] COEFF_RST = 16'd8041;

	localparam logic [2:0] MA_X = 3'd0;
	localparam logic [2:0] MA_Y = 3'd1;
	localparam logic [2:0] MA_Y2 = 3'd2;
	localparam logic [2:0] MA_Y3 = 3'd3;
	localparam logic [2:0] MA_Y5 = 3'd4;
	localparam logic [2:0] MA_PLAST = 3'd5;
	localparam logic [2:0] MA_D = 3'd6;

	localparam logic [2:0] MB_DRIVE = 3'd0;
	localparam logic [2:0] MB_C1 = 3'd1;
	localparam logic [2:0] MB_C3 = 3'd2;
	localparam logic [2:0] MB_C5 = 3'd3;
	localparam logic [2:0] MB_RES = 3'd4;
	localparam logic [2:0] MB_G = 3'd5;
	localparam logic [2:0] MB_Y = 3'd6;
	localparam logic [2:0] MB_Y2 = 3'd7;

	localparam logic [1:0] SH_3 = 2'd0;
	localparam logic [1:0] SH_12 = 2'd1;
	localparam logic [1:0] SH_16 = 2'd2;
	localparam logic [1:0] SH_24 = 2'd3;

	localparam logic [3:0] DST_Y = 4'd0;
	localparam logic [3:0] DST_FB = 4'd1;
	localparam logic [3:0] DST_Y2 = 4'd2;
	localparam logic [3:0] DST_T1 = 4'd3;
	localparam logic [3:0] DST_Y3 = 4'd4;
	localparam logic [3:0] DST_Y5 = 4'd5;
	localparam logic [3:0] DST_T3 = 4'd6;
	localparam logic [3:0] DST_T5 = 4'd7;
	localparam logic [3:0] DST_POLE = 4'd8;

	localparam logic [1:0] ALU_LIN = 2'd0;
	localparam logic [1:0] ALU_FBSUB = 2'd1;
	localparam logic [1:0] ALU_DIFF = 2'd2;

	localparam logic [1:0] JMP_NEXT = 2'd0;
	localparam logic [1:0] JMP_WAIT_IN = 2'd1;
	localparam logic [1:0] JMP_LOOP = 2'd2;
	localparam logic [1:0] JMP_WAIT_OUT = 2'd3;

	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_DRIVE = 5'd1;
	localparam logic [PC_W-1:0] PC_Y = 5'd2;
	localparam logic [PC_W-1:0] PC_FB = 5'd3;
	localparam logic [PC_W-1:0] PC_Y2 = 5'd4;
	localparam logic [PC_W-1:0] PC_T1 = 5'd5;
	localparam logic [PC_W-1:0] PC_Y3 = 5'd6;
	localparam logic [PC_W-1:0] PC_Y5M = 5'd7;
	localparam logic [PC_W-1:0] PC_Y5 = 5'd8;
	localparam logic [PC_W-1:0] PC_T3 = 5'd9;
	localparam logic [PC_W-1:0] PC_T5 = 5'd10;
	localparam logic [PC_W-1:0] PC_LIN = 5'd11;
	localparam logic [PC_W-1:0] PC_FBSUB = 5'd12;
	localparam logic [PC_W-1:0] PC_DIFF = 5'd13;
	localparam logic [PC_W-1:0] PC_GMUL = 5'd14;
	localparam logic [PC_W-1:0] PC_POLE = 5'd15;
	localparam logic [PC_W-1:0] PC_EMIT = 5'd16;

	typedef struct packed {
		logic mul_en;
		logic [2:0] ma_sel;
		logic [2:0] mb_sel;
		logic wb_en;
		logic [1:0] wb_sh;
		logic [3:0] wb_dst;
		logic alu_en;
		logic [1:0] alu_op;
		logic [1:0] jmp;
		logic [PC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		ucw_t cw;
		logic accept;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic clip;
		logic [DATA_W-1:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val = v[DATA_W-1:0];
		if (!v[PROD_W-1] && (|v[PROD_W-2:DATA_W-1])) begin
			r.clip = 1'b1;
			r.val = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v[PROD_W-1] && !(&v[PROD_W-2:DATA_W-1])) begin
			r.clip = 1'b1;
			r.val = {1'b1, {(DATA_W-1){1'b0}}};
		end
		return r;
	endfunction

	// control store
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t cw;
		cw = '0;
		cw.jmp = JMP_NEXT;
		cw.target = PC_IDLE;
		unique case (pc)
			PC_IDLE: begin
				cw.jmp = JMP_WAIT_IN;
			end
			PC_DRIVE: begin
				cw.mul_en = 1'b1; cw.ma_sel = MA_X; cw.mb_sel = MB_DRIVE;
			end
			PC_Y: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_3; cw.wb_dst = DST_Y;
				cw.mul_en = 1'b1; cw.ma_sel = MA_PLAST; cw.mb_sel = MB_RES;
			end
			PC_FB: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_12; cw.wb_dst = DST_FB;
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y; cw.mb_sel = MB_Y;
			end
			PC_Y2: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_24; cw.wb_dst = DST_Y2;
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y; cw.mb_sel = MB_C1;
			end
			PC_T1: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_16; cw.wb_dst = DST_T1;
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y2; cw.mb_sel = MB_Y;
			end
			PC_Y3: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_24; cw.wb_dst = DST_Y3;
			end
			PC_Y5M: begin
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y3; cw.mb_sel = MB_Y2;
			end
			PC_Y5: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_24; cw.wb_dst = DST_Y5;
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y3; cw.mb_sel = MB_C3;
			end
			PC_T3: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_16; cw.wb_dst = DST_T3;
				cw.mul_en = 1'b1; cw.ma_sel = MA_Y5; cw.mb_sel = MB_C5;
			end
			PC_T5: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_16; cw.wb_dst = DST_T5;
			end
			PC_LIN: begin
				cw.alu_en = 1'b1; cw.alu_op = ALU_LIN;
			end
			PC_FBSUB: begin
				cw.alu_en = 1'b1; cw.alu_op = ALU_FBSUB;
			end
			PC_DIFF: begin
				cw.alu_en = 1'b1; cw.alu_op = ALU_DIFF;
			end
			PC_GMUL: begin
				cw.mul_en = 1'b1; cw.ma_sel = MA_D; cw.mb_sel = MB_G;
			end
			PC_POLE: begin
				cw.wb_en = 1'b1; cw.wb_sh = SH_16; cw.wb_dst = DST_POLE;
				cw.jmp = JMP_LOOP; cw.target = PC_DIFF;
			end
			PC_EMIT: begin
				cw.jmp = JMP_WAIT_OUT; cw.target = PC_IDLE;
			end
			default: begin
				cw.jmp = JMP_WAIT_OUT; cw.target = PC_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hw/rtl/ladder_lowpass_with_predistortion.sv =====
// Four-pole ladder low-pass with odd polynomial pre-distortion.
// Input channel: in_valid / in_ready carry one signed Q1.15 dry_sample per request.
// Output channel: out_valid / out_ready carry sample_out (Q1.15, saturated) and
// clipped, which is set when any internal or output saturation hit that sample.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 drive, 1..3 shaper c1/c3/c5, 4 resonance, 5 pole coefficient); other
// indexes are dropped. Write only while the block is idle.
// The microcode program runs the eight shaper and feedback multiplies and the
// four pole updates in turn on a single shared 32x33 multiplier, one step per
// cycle while it is not waiting for an input sample or a free output register.
// A finished result waits in the output register; the next sample is taken and
// computed meanwhile, and the program holds on its last step until the output
// register is free, so a stalled receiver stops the block without losing data.
// Reset clears the pole state, loads register defaults and empties the output.
module ladder_lowpass_with_predistortion #(
	parameter int STAGE_COUNT = ladlp_pkg::STAGE_COUNT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ladlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ladlp_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ladlp_pkg::SAMPLE_W-1:0] dry_sample,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [ladlp_pkg::SAMPLE_W-1:0] sample_out,
	output logic clipped
);

	localparam int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

	ladlp_pkg::ctl_t ctl;
	logic [STAGE_W-1:0] stage;
	logic out_hold;

	ladlp_seq #(
		.STAGE_COUNT(STAGE_COUNT),
		.STAGE_W(STAGE_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_hold(out_hold),
		.stage(stage),
		.ctl(ctl)
	);

	ladlp_dp #(
		.STAGE_COUNT(STAGE_COUNT),
		.STAGE_W(STAGE_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.dry_sample(dry_sample),
		.ctl(ctl),
		.stage(stage),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_hold(out_hold),
		.sample_out(sample_out),
		.clipped(clipped)
	);

endmodule

// ===== hw/rtl/ladlp_seq.sv =====
module ladlp_seq #(
	parameter int STAGE_COUNT = ladlp_pkg::STAGE_COUNT,
	parameter int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_hold,
	output logic [STAGE_W-1:0] stage,
	output ladlp_pkg::ctl_t ctl
);

	logic [ladlp_pkg::PC_W-1:0] pc_q;
	logic [ladlp_pkg::PC_W-1:0] pc_d;
	logic [STAGE_W-1:0] stage_q;
	ladlp_pkg::ucw_t cw;
	logic last;

	assign cw = ladlp_pkg::ucode(pc_q);
	assign last = (stage_q == STAGE_W'(STAGE_COUNT - 1));

	always_comb begin
		case (cw.jmp)
			ladlp_pkg::JMP_WAIT_IN: pc_d = in_valid ? pc_q + ladlp_pkg::PC_W'(1) : pc_q;
			ladlp_pkg::JMP_LOOP: pc_d = last ? pc_q + ladlp_pkg::PC_W'(1) : cw.target;
			ladlp_pkg::JMP_WAIT_OUT: pc_d = out_hold ? pc_q : cw.target;
			default: pc_d = pc_q + ladlp_pkg::PC_W'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ladlp_pkg::PC_IDLE;
			stage_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (ctl.accept) begin
				stage_q <= '0;
			end else if (cw.jmp == ladlp_pkg::JMP_LOOP && !last) begin
				stage_q <= stage_q + STAGE_W'(1);
			end
		end
	end

	assign in_ready = (cw.jmp == ladlp_pkg::JMP_WAIT_IN);
	assign stage = stage_q;
	assign ctl.cw = cw;
	assign ctl.accept = in_ready && in_valid;
	assign ctl.emit = (cw.jmp == ladlp_pkg::JMP_WAIT_OUT) && !out_hold;

endmodule

// ===== hw/rtl/ladlp_dp.sv =====
module ladlp_dp #(
	parameter int STAGE_COUNT = ladlp_pkg::STAGE_COUNT,
	parameter int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ladlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ladlp_pkg::CFG_W-1:0] cfg_data,
	input  logic signed [ladlp_pkg::SAMPLE_W-1:0] dry_sample,
	input  ladlp_pkg::ctl_t ctl,
	input  logic [STAGE_W-1:0] stage,
	output logic out_valid,
	input  logic out_ready,
	output logic out_hold,
	output logic signed [ladlp_pkg::SAMPLE_W-1:0] sample_out,
	output logic clipped
);

	localparam int DW = ladlp_pkg::DATA_W;
	localparam int PW = ladlp_pkg::PROD_W;
	localparam int AW = ladlp_pkg::ACC_W;

	logic [15:0] drive_q;
	logic signed [19:0] c1_q;
	logic signed [19:0] c3_q;
	logic signed [19:0] c5_q;
	logic [15:0] res_q;
	logic [15:0] g_q;

	logic signed [ladlp_pkg::SAMPLE_W-1:0] x_q;
	logic signed [DW-1:0] y_q, y2_q, y3_q, y5_q, t1_q, t3_q, t5_q, fb_q, u_q, d_q;
	logic signed [DW-1:0] pole_q [STAGE_COUNT];
	logic signed [PW-1:0] prod_q;
	logic clip_q;

	logic out_valid_q;
	logic signed [ladlp_pkg::SAMPLE_W-1:0] sample_out_q;
	logic clipped_q;

	logic signed [DW-1:0] mul_a;
	logic signed [DW:0] mul_b;
	logic signed [DW-1:0] pole_cur;
	logic signed [DW-1:0] pole_last;
	logic signed [PW-1:0] rnd;
	logic signed [PW-1:0] wsum;
	ladlp_pkg::sat_t wsat;
	logic signed [AW-1:0] alu_a, alu_b, alu_c, alu_sum;
	ladlp_pkg::sat_t asat;
	logic signed [DW:0] ornd;
	logic signed [ladlp_pkg::SAMPLE_W-1:0] oval;
	logic oclip;

	assign pole_cur = pole_q[stage];
	assign pole_last = pole_q[STAGE_COUNT-1];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= ladlp_pkg::DRIVE_RST;
			c1_q <= ladlp_pkg::C1_RST;
			c3_q <= ladlp_pkg::C3_RST;
			c5_q <= ladlp_pkg::C5_RST;
			res_q <= ladlp_pkg::RES_RST;
			g_q <= ladlp_pkg::COEFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ladlp_pkg::REG_DRIVE: drive_q <= cfg_data[15:0];
				ladlp_pkg::REG_C1: c1_q <= cfg_data;
				ladlp_pkg::REG_C3: c3_q <= cfg_data;
				ladlp_pkg::REG_C5: c5_q <= cfg_data;
				ladlp_pkg::REG_RES: res_q <= cfg_data[15:0];
				ladlp_pkg::REG_COEFF: g_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// multiplier operands
	always_comb begin
		unique case (ctl.cw.ma_sel)
			ladlp_pkg::MA_X: mul_a = DW'(x_q);
			ladlp_pkg::MA_Y: mul_a = y_q;
			ladlp_pkg::MA_Y2: mul_a = y2_q;
			ladlp_pkg::MA_Y3: mul_a = y3_q;
			ladlp_pkg::MA_Y5: mul_a = y5_q;
			ladlp_pkg::MA_PLAST: mul_a = pole_last;
			ladlp_pkg::MA_D: mul_a = d_q;
			default: mul_a = '0;
		endcase
		unique case (ctl.cw.mb_sel)
			ladlp_pkg::MB_DRIVE: mul_b = $signed({17'd0, drive_q});
			ladlp_pkg::MB_C1: mul_b = (DW+1)'(c1_q);
			ladlp_pkg::MB_C3: mul_b = (DW+1)'(c3_q);
			ladlp_pkg::MB_C5: mul_b = (DW+1)'(c5_q);
			ladlp_pkg::MB_RES: mul_b = $signed({17'd0, res_q});
			ladlp_pkg::MB_G: mul_b = $signed({17'd0, g_q});
			ladlp_pkg::MB_Y: mul_b = (DW+1)'(y_q);
			ladlp_pkg::MB_Y2: mul_b = (DW+1)'(y2_q);
			default: mul_b = '0;
		endcase
	end

	// product writeback: round, optional pole add, saturate
	always_comb begin
		case (ctl.cw.wb_sh)
			ladlp_pkg::SH_3: rnd = (prod_q + PW'(64'sd4)) >>> 3;
			ladlp_pkg::SH_12: rnd = (prod_q + PW'(64'sd2048)) >>> 12;
			ladlp_pkg::SH_16: rnd = (prod_q + PW'(64'sd32768)) >>> 16;
			default: rnd = (prod_q + PW'(64'sd8388608)) >>> 24;
		endcase
		if (ctl.cw.wb_dst == ladlp_pkg::DST_POLE) begin
			wsum = rnd + PW'(pole_cur);
		end else begin
			wsum = rnd;
		end
		wsat = ladlp_pkg::sat32(wsum);
	end

	// add/subtract unit
	always_comb begin
		unique case (ctl.cw.alu_op)
			ladlp_pkg::ALU_LIN: begin
				alu_a = AW'(t1_q); alu_b = AW'(t3_q); alu_c = AW'(t5_q);
			end
			ladlp_pkg::ALU_FBSUB: begin
				alu_a = AW'(u_q); alu_b = -AW'(fb_q); alu_c = '0;
			end
			ladlp_pkg::ALU_DIFF: begin
				alu_a = AW'(u_q); alu_b = -AW'(pole_cur); alu_c = '0;
			end
			default: begin
				alu_a = '0; alu_b = '0; alu_c = '0;
			end
		endcase
		alu_sum = alu_a + alu_b + alu_c;
		asat = ladlp_pkg::sat32(PW'(alu_sum));
	end

	// output rounding and clamp
	always_comb begin
		ornd = ((DW+1)'(pole_last) + (DW+1)'(33'sd256)) >>> 9;
		oclip = 1'b0;
		oval = ornd[ladlp_pkg::SAMPLE_W-1:0];
		if (ornd > (DW+1)'(33'sd32767)) begin
			oval = 16'sh7FFF;
			oclip = 1'b1;
		end else if (ornd < -(DW+1)'(33'sd32768)) begin
			oval = 16'sh8000;
			oclip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			x_q <= dry_sample;
		end
		if (ctl.cw.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.cw.wb_en) begin
			case (ctl.cw.wb_dst)
				ladlp_pkg::DST_Y: y_q <= $signed(wsat.val);
				ladlp_pkg::DST_FB: fb_q <= $signed(wsat.val);
				ladlp_pkg::DST_Y2: y2_q <= $signed(wsat.val);
				ladlp_pkg::DST_T1: t1_q <= $signed(wsat.val);
				ladlp_pkg::DST_Y3: y3_q <= $signed(wsat.val);
				ladlp_pkg::DST_Y5: y5_q <= $signed(wsat.val);
				ladlp_pkg::DST_T3: t3_q <= $signed(wsat.val);
				ladlp_pkg::DST_T5: t5_q <= $signed(wsat.val);
				ladlp_pkg::DST_POLE: u_q <= $signed(wsat.val);
				default: ;
			endcase
		end
		if (ctl.cw.alu_en) begin
			if (ctl.cw.alu_op == ladlp_pkg::ALU_DIFF) begin
				d_q <= $signed(asat.val);
			end else begin
				u_q <= $signed(asat.val);
			end
		end
		if (ctl.emit) begin
			sample_out_q <= oval;
			clipped_q <= clip_q | oclip;
		end
	end

	// pole state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGE_COUNT; i++) begin
				pole_q[i] <= '0;
			end
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cw.wb_en && ctl.cw.wb_dst == ladlp_pkg::DST_POLE) begin
				pole_q[stage] <= $signed(wsat.val);
			end
			if (ctl.accept) begin
				clip_q <= 1'b0;
			end else if ((ctl.cw.wb_en && wsat.clip) || (ctl.cw.alu_en && asat.clip)) begin
				clip_q <= 1'b1;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_hold = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped = clipped_q;

endmodule
